// ===== hdl/keyframe_position_lerp_assert.svh =====
// Assertion macros shared by the keyframe interpolator checker.
// Included by the checker file; holds nothing but macro definitions.
`ifndef KEYFRAME_POSITION_LERP_ASSERT_SVH
`define KEYFRAME_POSITION_LERP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define KPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define KPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/kfl_pkg.sv =====
// Package for the keyframe interpolator: status codes, constants, FSM states, divider request.
// No dependencies.
`timescale 1ns / 1ps
package kfl_pkg;
  localparam int KEYS_DEFAULT = 64;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    STATUS_QUERY = 2'd0,
    STATUS_STORED = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_NEXT_RD,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

// ===== hdl/kfl_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/kfl_div.sv =====
// Restoring radix-2 divider, 48-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on kfl_pkg.
`timescale 1ns / 1ps
module kfl_div
  import kfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [15:0] quot
);
  logic [47:0] num;
  logic [32:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], num[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[46:0], ~trial[32]};
        rem <= trial[32] ? {rem[31:0], num[47]} : trial;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient is below 2^16 because t - t0 < t1 - t0.
  assign quot = num[15:0];
endmodule

// ===== hdl/keyframe_position_lerp.sv =====
// Keyframe position interpolator: sorted key table in a synchronous RAM, a
// sequencer that scans and shifts, a serial divider and a shared multiplier.
// Depends on kfl_pkg, kfl_ram and kfl_div.
//
// One item is handled at a time. An insert scans the sorted table one key per
// RAM read, then, for a new time and when there is room, moves every later key
// up one slot, reading and writing each, and writes the new key. The scanned
// keys and the moved keys together never exceed the key count. A query scans
// to the first key after the query time, reads that key, runs the serial
// divider, and does three multiplies on the one 33x17 multiplier; with no
// later key it returns the base key. The result sits in an output register,
// and the next transfer is taken as soon as it has been taken. The table
// memory needs no clearing after reset; the key count bounds every read.
`timescale 1ns / 1ps
module keyframe_position_lerp
  import kfl_pkg::*;
#(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [1:0]         status
);
  localparam int AW = $clog2(KEYS);
  localparam int CW = $clog2(KEYS + 1);
  localparam logic [CW-1:0] KEYS_C = CW'(KEYS);

  state_t state, state_next;

  // Latched item.
  logic        op_query;
  logic [31:0] t_in;
  logic [31:0] x_in, y_in, z_in;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;     // scan position
  logic [CW-1:0] sh;      // shift source + 1

  // Base key (last key at or before t) and target key.
  logic [31:0] t0;
  logic [31:0] b_val [3];
  logic [31:0] n_val [3];
  logic [15:0] inter;
  logic [1:0]  ax;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [31:0] res [3];
  logic        dup_w;  // insert matched an existing time

  // One RAM holds a whole key: time and the three coordinates side by side.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wd_t, wd_x, wd_y, wd_z;
  logic [31:0]   rd_t, rd_x, rd_y, rd_z;
  logic [127:0]  rd_key;

  kfl_ram #(.WIDTH(128), .DEPTH(KEYS)) u_ram (.clk, .we, .waddr,
    .wdata({wd_t, wd_x, wd_y, wd_z}), .raddr, .rdata(rd_key));
  assign {rd_t, rd_x, rd_y, rd_z} = rd_key;

  div_req_t    dreq;
  logic        ddone;
  logic [15:0] dquot;
  kfl_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quot(dquot));

  assign in_ready = (state == ST_IDLE) && !out_valid;

  logic scan_end, at_key, dup;
  assign scan_end = (idx == count);
  assign at_key   = !scan_end && (rd_t <= t_in);
  assign dup      = !scan_end && (rd_t == t_in);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_SCAN_REQ;
      ST_SCAN_REQ: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (op_query) begin
          if (at_key) state_next = ST_SCAN_REQ;
          else if (scan_end) state_next = ST_OUT;
          else state_next = ST_DIV;
        end else begin
          if (!scan_end && rd_t < t_in) state_next = ST_SCAN_REQ;
          else if (dup) state_next = ST_WRITE;
          else if (count == KEYS_C) state_next = ST_OUT;
          else if (sh == idx) state_next = ST_WRITE;
          else state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = (sh - CW'(1) == idx) ? ST_WRITE : ST_SHIFT_RD;
      ST_WRITE: state_next = ST_OUT;
      ST_DIV: if (ddone) state_next = ST_MUL;
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = (ax == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM addressing and divider request.
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    raddr = idx[AW-1:0];
    wd_t  = t_in;
    wd_x  = x_in;
    wd_y  = y_in;
    wd_z  = z_in;
    dreq.start    = 1'b0;
    dreq.dividend = {t_in - t0, 16'd0};
    dreq.divisor  = rd_t - t0;
    case (state)
      ST_SHIFT_RD: raddr = AW'(sh - CW'(1));
      ST_SHIFT_WR: begin
        we    = 1'b1;
        waddr = sh[AW-1:0];
        wd_t  = rd_t;
        wd_x  = rd_x;
        wd_y  = rd_y;
        wd_z  = rd_z;
      end
      ST_WRITE: we = 1'b1;
      ST_SCAN_CHK: dreq.start = op_query && !at_key && !scan_end;
      default: ;
    endcase
  end

  // The coordinate difference needs 33 bits to span the full signed range.
  assign diff = $signed({n_val[ax][31], n_val[ax]}) - $signed({b_val[ax][31], b_val[ax]});
  assign prod = $signed({1'b0, inter}) * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_OUT) out_valid <= 1'b1;
      if (state == ST_WRITE && !dup_w) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        op_query <= kind;
        t_in <= key_time;
        x_in <= value_x;
        y_in <= value_y;
        z_in <= value_z;
        idx <= '0;
        sh <= count;
        dup_w <= 1'b0;
        t0 <= '0;
        b_val[0] <= ONE_Q16;
        b_val[1] <= ONE_Q16;
        b_val[2] <= ONE_Q16;
        ax <= 2'd0;
      end
      ST_SCAN_CHK: begin
        if (op_query ? at_key : (!scan_end && rd_t < t_in)) begin
          idx <= idx + CW'(1);
          if (op_query) begin
            t0 <= rd_t;
            b_val[0] <= rd_x;
            b_val[1] <= rd_y;
            b_val[2] <= rd_z;
          end
        end
        if (!op_query) dup_w <= dup;
        n_val[0] <= rd_x;
        n_val[1] <= rd_y;
        n_val[2] <= rd_z;
        if (!op_query) status <= (!dup && count == KEYS_C) ? STATUS_FULL : STATUS_STORED;
        else status <= STATUS_QUERY;
      end
      ST_SHIFT_WR: sh <= sh - CW'(1);
      ST_DIV: if (ddone) inter <= dquot;
      ST_MUL: res[ax] <= 32'(prod >>> 16);
      ST_SUM: begin
        res[ax] <= res[ax] + b_val[ax];
        ax <= ax + 2'd1;
      end
      ST_OUT: begin
        if (!op_query) begin
          pos_x <= '0;
          pos_y <= '0;
          pos_z <= '0;
        end else if (ax == 2'd0) begin
          pos_x <= b_val[0];
          pos_y <= b_val[1];
          pos_z <= b_val[2];
        end else begin
          pos_x <= res[0];
          pos_y <= res[1];
          pos_z <= res[2];
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/kfl_checker.sv =====
// Port-level checker for the keyframe interpolator, bound to the top level.
// Depends on kfl_pkg and keyframe_position_lerp_assert.svh.
`timescale 1ns / 1ps
`include "keyframe_position_lerp_assert.svh"
module kfl_checker
  import kfl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [31:0] pos_x,
  input logic [1:0] status
);
  // A stalled result holds: valid, status and pos_x stay.
  `KPL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(pos_x), "result dropped while stalled")
  // No new transfer while a result waits.
  `KPL_ASSERT_IMP(a_one_item, clk, rst, out_valid, !in_ready, "input taken with result pending")
  // Status code of a valid result is never the reserved value.
  `KPL_ASSERT_IMP(a_status, clk, rst, out_valid, status != 2'd3, "bad status")
  // Input taken means no result in the next cycle.
  `KPL_ASSERT_NEXT(a_no_early, clk, rst, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind keyframe_position_lerp kfl_checker u_kfl_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .pos_x, .status
);

// ===== bench/keyframe_position_lerp_test.sv =====
// Testbench for keyframe_position_lerp: drives inserts and queries over valid/ready,
// predicts every result with a behavioral key table, and checks results in order.
// Depends on kfl_pkg and the keyframe_position_lerp RTL.
`timescale 1ns / 1ps
module keyframe_position_lerp_test
  import kfl_pkg::*;
();

  localparam int NKEYS = 64;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_t st;
  } position_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [31:0] key_time = '0;
  logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [1:0] status;

  keyframe_position_lerp dut (
    .clk, .rst, .in_valid, .in_ready, .kind, .key_time, .value_x, .value_y,
    .value_z, .out_valid, .out_ready, .pos_x, .pos_y, .pos_z, .status
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The predictor's own copy of the sorted key table.
  logic [31:0] tbl_time [NKEYS];
  logic signed [31:0] tbl_x [NKEYS], tbl_y [NKEYS], tbl_z [NKEYS];
  int tbl_count = 0;

  position_t expected_positions[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  // floor(inter * (p1 - p0) / 2^16) added to p0, done in 64-bit signed math.
  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] p0,
                                                   logic signed [31:0] p1,
                                                   longint inter);
    longint d;
    longint r;
    d = longint'(p1) - longint'(p0);
    r = longint'(p0) + ((inter * d) >>> 16);
    return r[31:0];
  endfunction

  function automatic position_t predict_position(logic k, logic [31:0] t,
                                                 logic signed [31:0] x,
                                                 logic signed [31:0] y,
                                                 logic signed [31:0] z);
    position_t res;
    int slot;
    int nxt;
    logic [31:0] t0;
    logic signed [31:0] x0, y0, z0;
    longint inter;
    res = '{x: 0, y: 0, z: 0, st: STATUS_STORED};
    if (k == KIND_INSERT) begin
      slot = 0;
      while (slot < tbl_count && tbl_time[slot] < t) slot++;
      if (slot < tbl_count && tbl_time[slot] == t) begin
        tbl_x[slot] = x; tbl_y[slot] = y; tbl_z[slot] = z;
      end else if (tbl_count >= NKEYS) begin
        res.st = STATUS_FULL;
      end else begin
        for (int i = tbl_count; i > slot; i--) begin
          tbl_time[i] = tbl_time[i-1];
          tbl_x[i] = tbl_x[i-1]; tbl_y[i] = tbl_y[i-1]; tbl_z[i] = tbl_z[i-1];
        end
        tbl_time[slot] = t;
        tbl_x[slot] = x; tbl_y[slot] = y; tbl_z[slot] = z;
        tbl_count++;
      end
      return res;
    end
    // Query: the implicit base at time zero is 1.0 on every axis.
    t0 = '0; x0 = ONE_Q16; y0 = ONE_Q16; z0 = ONE_Q16;
    nxt = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_time[i] <= t) begin
        t0 = tbl_time[i]; x0 = tbl_x[i]; y0 = tbl_y[i]; z0 = tbl_z[i];
      end else begin
        nxt = i;
        break;
      end
    end
    res.st = STATUS_QUERY;
    if (nxt < 0) begin
      res.x = x0; res.y = y0; res.z = z0;
    end else begin
      inter = ((longint'(t) - longint'(t0)) <<< 16) /
              (longint'(tbl_time[nxt]) - longint'(t0));
      res.x = lerp_axis(x0, tbl_x[nxt], inter);
      res.y = lerp_axis(y0, tbl_y[nxt], inter);
      res.z = lerp_axis(z0, tbl_z[nxt], inter);
    end
    return res;
  endfunction

  // Sends one item: valid is raised, held with its payload until the transfer,
  // and the expectation is recorded at the accepting edge. Valid stays high
  // when the caller has another item ready right away.
  task automatic send_item(logic k, logic [31:0] t, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z);
    in_valid <= 1'b1;
    kind <= k; key_time <= t; value_x <= x; value_y <= y; value_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_positions.push_back(predict_position(k, t, x, y, z));
  endtask

  // Bursty sender: after a burst ends, valid drops for a random gap, or for none.
  int burst_left = 0;
  task automatic paced_send(logic k, logic [31:0] t, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_item(k, t, x, y, z);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return ONE_Q16;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: a stall pattern of its own, plus a long hold-off on request.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) out_ready <= 1'b0;
      else if (phase % 400 < 150) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker: each transfer on the output side is compared with the
  // oldest expectation.
  initial begin
    position_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
        end else begin
          want = expected_positions.pop_front();
          if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z ||
              status !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h %h %h st %0d, got %h %h %h st %0d",
                       want.x, want.y, want.z, want.st, pos_x, pos_y, pos_z, status);
          end
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(KIND_QUERY, 32'd0, 0, 0, 0);
    send_item(KIND_QUERY, 32'hffff_ffff, 0, 0, 0);
    drain_and_idle();
  endtask

  // Extremes of fields, exact-time hits, replacement and the hold past the end.
  task automatic test_directed_keys();
    send_item(KIND_INSERT, 32'd100, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    send_item(KIND_INSERT, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_item(KIND_QUERY, 32'd0, 0, 0, 0);
    send_item(KIND_QUERY, 32'd50, 0, 0, 0);
    send_item(KIND_QUERY, 32'd100, 0, 0, 0);
    send_item(KIND_QUERY, 32'd99, 0, 0, 0);
    send_item(KIND_INSERT, 32'hffff_ffff, 32'h1234_5678, 32'hedcb_a987, ONE_Q16);
    send_item(KIND_QUERY, 32'hffff_fffe, 0, 0, 0);
    send_item(KIND_QUERY, 32'hffff_ffff, 0, 0, 0);
    send_item(KIND_INSERT, 32'd100, 32'd5, 32'd6, 32'd7);
    send_item(KIND_QUERY, 32'd101, 0, 0, 0);
    drain_and_idle();
  endtask

  // Fill the table, then see new keys dropped and existing ones replaced.
  task automatic test_full_table();
    logic [31:0] t;
    while (tbl_count < NKEYS)
      paced_send(KIND_INSERT, $urandom(), rand_coord(), rand_coord(), rand_coord());
    for (int i = 0; i < 20; i++) begin
      t = ($urandom_range(0, 1) != 0) ? tbl_time[$urandom_range(0, NKEYS - 1)]
                                      : $urandom();
      paced_send(KIND_INSERT, t, rand_coord(), rand_coord(), rand_coord());
      paced_send(KIND_QUERY, ($urandom_range(0, 1) != 0) ? t : $urandom(), 0, 0, 0);
    end
    drain_and_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++)
        send_item(KIND_QUERY, $urandom(), 0, 0, 0);
    join
    drain_and_idle();
  endtask

  // Random mix of inserts and queries. The table is never cleared; with
  // small time ranges queries often hit keys and intervals.
  task automatic test_random_mix(int n_items, logic [31:0] span);
    logic [31:0] t;
    for (int i = 0; i < n_items; i++) begin
      t = (span == 0) ? $urandom() : $urandom_range(0, span);
      if (tbl_count > 0 && $urandom_range(0, 4) == 0)
        t = tbl_time[$urandom_range(0, tbl_count - 1)] + $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0)
        paced_send(KIND_INSERT, t, rand_coord(), rand_coord(), rand_coord());
      else
        paced_send(KIND_QUERY, t, rand_coord(), rand_coord(), rand_coord());
    end
    drain_and_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_keys();
    test_random_mix(300, 32'd5000);
    test_full_table();
    test_backpressure();
    test_random_mix(1000, 32'd0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_positions.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Slowest run: ~1450 items plus stalls.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/kfl_pkg.sv
hdl/kfl_ram.sv
hdl/kfl_div.sv
hdl/keyframe_position_lerp.sv
hdl/kfl_checker.sv
bench/keyframe_position_lerp_test.sv
